### rtl/core/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        func_t                      func;
        logic signed [VALUE_W-1:0]  value;
    } spq_in_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0]  out_value;
        logic                       out_valid;
        status_t                    status;
        logic [CNT_W-1:0]           count;
        logic                       empty_res;
        logic                       full_res;
    } spq_out_t;

    // Broadcast to every cell of the row
    typedef struct packed
    {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
    } spq_cmd_t;

endpackage

### rtl/core/spq_cell.sv
module spq_cell
(
    input  logic                                clk,
    input  spq_pkg::spq_cmd_t                   cmd,
    input  logic                                occupied,
    input  logic                                left_less,
    input  logic signed [spq_pkg::VALUE_W-1:0]  left_entry,
    input  logic signed [spq_pkg::VALUE_W-1:0]  right_entry,
    output logic signed [spq_pkg::VALUE_W-1:0]  entry,
    output logic                                less
);

    logic signed [spq_pkg::VALUE_W-1:0] entry_reg;
    logic signed [spq_pkg::VALUE_W-1:0] entry_next;

    // Stored values below the new one stay put; the first cell that is not
    // below takes the new value and the rest take their left neighbour.
    assign less = occupied && (entry_reg < cmd.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.rem)
        begin
            entry_next = right_entry;
        end
        else if (cmd.ins && !less)
        begin
            entry_next = left_less ? cmd.value : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/core/sorted_insert_priority_queue_top.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// A transaction's result is captured in the result register when it is accepted.
// Throughput: one operation per cycle; every cell compares and shifts in parallel,
// and a new transaction is taken whenever the result register is empty or being read.
// Reset clears the fill count and the result valid flag; stored values are not
// cleared and only positions below the fill count are ever read.
module sorted_insert_priority_queue_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spq_pkg::spq_in_t   in_data,
    output logic               res_valid,
    input  logic               res_ready,
    output spq_pkg::spq_out_t  res_data
);

    logic [spq_pkg::CNT_W-1:0]  count_reg;
    logic [spq_pkg::CNT_W-1:0]  count_next;
    logic                       res_valid_reg;
    spq_pkg::spq_out_t          res_reg;
    spq_pkg::spq_out_t          res_next;

    logic                       accept;
    logic                       is_full;
    logic                       is_empty;
    logic                       do_ins;
    logic                       do_rem;
    spq_pkg::spq_cmd_t          cmd;

    logic signed [spq_pkg::VALUE_W-1:0] entry_w       [spq_pkg::DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0] left_entry_w  [spq_pkg::DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0] right_entry_w [spq_pkg::DEPTH];
    logic                               less_w        [spq_pkg::DEPTH];
    logic                               left_less_w   [spq_pkg::DEPTH];
    logic                               occupied_w    [spq_pkg::DEPTH];

    assign in_ready = !res_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == spq_pkg::DEPTH_CNT);
    assign is_empty = (count_reg == '0);
    assign do_ins   = accept && (in_data.func == spq_pkg::FUNC_INSERT) && !is_full;
    assign do_rem   = accept && (in_data.func == spq_pkg::FUNC_REMOVE) && !is_empty;

    assign cmd.ins   = do_ins;
    assign cmd.rem   = do_rem;
    assign cmd.value = in_data.value;

    genvar i;
    generate
        for (i = 0; i < spq_pkg::DEPTH; i++)
        begin : g_cell
            assign occupied_w[i] = (spq_pkg::CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign left_less_w[i]  = 1'b1;
                assign left_entry_w[i] = '0;
            end
            else
            begin : g_body
                assign left_less_w[i]  = less_w[i-1];
                assign left_entry_w[i] = entry_w[i-1];
            end

            if (i == spq_pkg::DEPTH - 1)
            begin : g_tail
                assign right_entry_w[i] = '0;
            end
            else
            begin : g_mid
                assign right_entry_w[i] = entry_w[i+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occupied_w[i]),
                .left_less   (left_less_w[i]),
                .left_entry  (left_entry_w[i]),
                .right_entry (right_entry_w[i]),
                .entry       (entry_w[i]),
                .less        (less_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + spq_pkg::CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - spq_pkg::CNT_W'(1);
        end

        res_next.out_value = do_rem ? entry_w[0] : '0;
        res_next.out_valid = do_rem;
        res_next.count     = count_next;
        res_next.empty_res = (count_next == '0);
        res_next.full_res  = (count_next == spq_pkg::DEPTH_CNT);
        if ((in_data.func == spq_pkg::FUNC_INSERT) && is_full)
        begin
            res_next.status = spq_pkg::STATUS_FULL;
        end
        else if ((in_data.func == spq_pkg::FUNC_REMOVE) && is_empty)
        begin
            res_next.status = spq_pkg::STATUS_EMPTY;
        end
        else
        begin
            res_next.status = spq_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::DEPTH_CNT)
        else $error("fill count beyond depth");

    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_rem |=> (count_reg == $past(count_reg) - spq_pkg::CNT_W'(1)))
        else $error("remove did not drop fill count by one");

    a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !do_ins && !do_rem) |=> $stable(count_reg))
        else $error("refused transaction changed fill count");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted transaction produced no result");

    generate
        for (i = 0; i < spq_pkg::DEPTH - 1; i++)
        begin : g_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (spq_pkg::CNT_W'(i + 1) < count_reg) |-> (entry_w[i] <= entry_w[i+1]))
                else $error("stored values out of order");
        end
    endgenerate

endmodule

### tb/tb_sorted_insert_priority_queue_top.sv
module tb_sorted_insert_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS = 1200;
    localparam int TAIL_OPS   = 150;
    localparam int LONG_HOLD  = 60;

    typedef struct
    {
        spq_pkg::spq_in_t  op;
        logic              typed;
        spq_pkg::spq_out_t want;
    } directed_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    spq_pkg::spq_in_t  in_data   = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    spq_pkg::spq_out_t res_data;

    // Typed expectation travelling alongside the transaction on offer
    logic              drive_typed = 1'b0;
    spq_pkg::spq_out_t drive_want  = '0;

    logic signed [spq_pkg::VALUE_W-1:0] shadow_vals [spq_pkg::DEPTH];
    int                                 shadow_fill    = 0;
    spq_pkg::spq_out_t                  outcomes_due [$];
    directed_row_t                      directed_rows [$];
    int                                 errors         = 0;
    int                                 results_taken  = 0;
    bit                                 tail_mode      = 1'b0;
    bit                                 long_hold_done = 1'b0;

    sorted_insert_priority_queue_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    function automatic spq_pkg::spq_in_t make_op(spq_pkg::func_t f,
                                                 logic signed [spq_pkg::VALUE_W-1:0] v);
        spq_pkg::spq_in_t op;
        op.func  = f;
        op.value = v;
        return op;
    endfunction

    function automatic spq_pkg::spq_out_t make_res(logic signed [spq_pkg::VALUE_W-1:0] v,
                                                   logic vld, spq_pkg::status_t st,
                                                   int cnt, logic emp, logic ful);
        spq_pkg::spq_out_t r;
        r.out_value = v;
        r.out_valid = vld;
        r.status    = st;
        r.count     = spq_pkg::CNT_W'(cnt);
        r.empty_res = emp;
        r.full_res  = ful;
        return r;
    endfunction

    // Apply one operation to the shadow store and return its outcome
    function automatic spq_pkg::spq_out_t shadow_queue_op(spq_pkg::spq_in_t op);
        spq_pkg::spq_out_t res;
        int                pos;
        int                i;
        res        = '0;
        res.status = spq_pkg::STATUS_OK;
        if (op.func == spq_pkg::FUNC_INSERT)
        begin
            if (shadow_fill >= spq_pkg::DEPTH)
                res.status = spq_pkg::STATUS_FULL;
            else
            begin
                // equal values: the new one goes ahead of earlier equal ones; stop at the first one not smaller
                pos = 0;
                while (pos < shadow_fill && shadow_vals[pos] < op.value)
                    pos++;
                for (i = shadow_fill; i > pos; i--)
                    shadow_vals[i] = shadow_vals[i-1];
                shadow_vals[pos] = op.value;
                shadow_fill++;
            end
        end
        else
        begin
            if (shadow_fill == 0)
                res.status = spq_pkg::STATUS_EMPTY;
            else
            begin
                res.out_value = shadow_vals[0];
                res.out_valid = 1'b1;
                for (i = 1; i < shadow_fill; i++)
                    shadow_vals[i-1] = shadow_vals[i];
                shadow_fill--;
            end
        end
        res.count     = spq_pkg::CNT_W'(shadow_fill);
        res.empty_res = (shadow_fill == 0);
        res.full_res  = (shadow_fill == spq_pkg::DEPTH);
        return res;
    endfunction

    function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return spq_pkg::VALUE_W'(int'($urandom_range(0, 8)) - 4);
            7:          return {1'b0, {(spq_pkg::VALUE_W-1){1'b1}}} - $urandom_range(0, 2);
            8:          return {1'b1, {(spq_pkg::VALUE_W-1){1'b0}}} + $urandom_range(0, 2);
            default:    return -1;
        endcase
    endfunction

    task automatic check_field(string name, logic [spq_pkg::VALUE_W-1:0] want,
                               logic [spq_pkg::VALUE_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic offer(spq_pkg::spq_in_t op, logic typed, spq_pkg::spq_out_t want);
        in_valid    <= 1'b1;
        in_data     <= op;
        drive_typed <= typed;
        drive_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (!tail_mode && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Outcomes are checked before the new transaction is predicted
    always @(posedge clk)
    begin
        spq_pkg::spq_out_t want;
        if (res_valid && res_ready)
        begin
            results_taken++;
            if (outcomes_due.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %p", $time, res_data);
            end
            else
            begin
                want = outcomes_due.pop_front();
                check_field("out_value", want.out_value, res_data.out_value);
                check_field("out_valid", want.out_valid, res_data.out_valid);
                check_field("status",    want.status,    res_data.status);
                check_field("count",     want.count,     res_data.count);
                check_field("empty_res", want.empty_res, res_data.empty_res);
                check_field("full_res",  want.full_res,  res_data.full_res);
            end
        end
        if (in_valid && in_ready)
        begin
            want = shadow_queue_op(in_data);
            if (drive_typed)
                want = drive_want;
            outcomes_due.push_back(want);
        end
    end

    initial
    begin
        spq_pkg::spq_in_t op;
        int               n;
        int               k;
        int               mode_left;
        int               insert_pct;
        mode_left  = 0;
        insert_pct = 50;

        directed_rows.push_back('{make_op(spq_pkg::FUNC_REMOVE, 0), 1'b1,
                                  make_res(0, 1'b0, spq_pkg::STATUS_EMPTY, 0, 1'b1, 1'b0)});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'sh8000_0000), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 0), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, -1), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, -1), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_REMOVE, 32'sh7FFF_FFFF), 1'b1,
                                  make_res(32'sh8000_0000, 1'b1, spq_pkg::STATUS_OK, 4,
                                           1'b0, 1'b0)});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 1), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, -2), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 100), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'sh4000_0000), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'sh5555_5555), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'shAAAA_AAAA), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, -100), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 0), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 7), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'sh7FFF_FFFE), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 32'sh8000_0001), 1'b0, '0});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 3), 1'b0, '0});
        // store now holds DEPTH values: this one is refused
        directed_rows.push_back('{make_op(spq_pkg::FUNC_INSERT, 5), 1'b1,
                                  make_res(0, 1'b0, spq_pkg::STATUS_FULL, spq_pkg::DEPTH,
                                           1'b0, 1'b1)});
        directed_rows.push_back('{make_op(spq_pkg::FUNC_REMOVE, 0), 1'b0, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed_rows.size(); k++)
        begin
            offer(directed_rows[k].op, directed_rows[k].typed, directed_rows[k].want);
            maybe_gap();
        end

        // Switch at random among fill-heavy, balanced and drain-heavy stretches to sweep between empty and full
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS - TAIL_OPS)
                tail_mode = 1'b1;
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    default: insert_pct = 80;
                endcase
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            op.func  = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                             : spq_pkg::FUNC_REMOVE;
            op.value = pick_value();
            offer(op, 1'b0, '0);
            if (n == RANDOM_OPS / 2)
            begin
                // hold the sender until every outstanding result has been read
                in_valid <= 1'b0;
                @(posedge clk);
                while (outcomes_due.size() != 0)
                    @(posedge clk);
            end
            else
                maybe_gap();
        end

        in_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (tail_mode)
            begin
                res_ready <= 1'b1;
                @(posedge clk);
            end
            else if (!long_hold_done && results_taken >= 300)
            begin
                // long hold-off: let the block back up and stall its input
                long_hold_done = 1'b1;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
